### hdl/gapf_pkg.sv
// ----------------------------------------------------------------------------
// gapf_pkg
// Shared types and constants of the grid A* path finder.
// ----------------------------------------------------------------------------
package gapf_pkg;

  localparam int COORD_W = 6;
  localparam int GRID_W  = 1 << COORD_W;
  localparam int GRID_H  = 1 << COORD_W;
  localparam int CELL_W  = 2 * COORD_W;
  localparam int NCELLS  = GRID_W * GRID_H;
  localparam int CNT_W   = CELL_W + 1;
  localparam int F_W     = CELL_W + 1;
  localparam int KEY_W   = F_W + CELL_W;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // open-set key: {f = cost + distance, cell}
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
    key_t key;
  } heap_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
    key_t top;
  } heap_sts_t;

endpackage

### hdl/gapf_heap.sv
// ----------------------------------------------------------------------------
// gapf_heap
// Binary min-heap of open-set keys in one synchronous memory; push sifts up,
// pop returns the top and sifts the last entry down, one read per cycle.
// ----------------------------------------------------------------------------
module gapf_heap (
  input  logic                clk,
  input  logic                rst_n,
  input  gapf_pkg::heap_cmd_t cmd,
  output gapf_pkg::heap_sts_t sts
);
  import gapf_pkg::*;

  localparam logic [3:0] H_IDLE  = 4'd0;
  localparam logic [3:0] H_PUP   = 4'd1;
  localparam logic [3:0] H_FIN   = 4'd2;
  localparam logic [3:0] H_POPT  = 4'd3;
  localparam logic [3:0] H_POPL  = 4'd4;
  localparam logic [3:0] H_PDN   = 4'd5;
  localparam logic [3:0] H_PDC0  = 4'd6;
  localparam logic [3:0] H_PDC1  = 4'd7;
  localparam logic [3:0] H_PDCMP = 4'd8;

  key_t heap_mem [NCELLS];
  key_t rdata_r;

  logic [3:0]        st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CELL_W-1:0] idx_r, idx_nxt;
  logic [CELL_W-1:0] cidx_r, cidx_nxt;
  key_t              key_r, key_nxt;
  key_t              best_r, best_nxt;
  key_t              top_r, top_nxt;

  logic              re, we;
  logic [CELL_W-1:0] raddr, waddr;
  key_t              wdata;
  logic [CELL_W-1:0] par_idx, cnt_m1;
  logic [CNT_W-1:0]  c_w, c1_w;

  assign par_idx = (idx_r - CELL_W'(1)) >> 1;
  assign cnt_m1  = cnt_r[CELL_W-1:0] - CELL_W'(1);
  assign c_w     = {idx_r, 1'b1};
  assign c1_w    = c_w + CNT_W'(1);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    cidx_nxt = cidx_r;
    key_nxt  = key_r;
    best_nxt = best_r;
    top_nxt  = top_r;
    re       = 1'b0;
    we       = 1'b0;
    raddr    = '0;
    waddr    = idx_r;
    wdata    = key_r;
    case (st_r)
      H_IDLE: begin
        if (cmd.clr) begin
          cnt_nxt = '0;
        end else if (cmd.push && cnt_r < CNT_W'(NCELLS)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = cmd.key;
          end else begin
            key_nxt = cmd.key;
            idx_nxt = cnt_r[CELL_W-1:0];
            re      = 1'b1;
            raddr   = cnt_m1 >> 1;
            st_nxt  = H_PUP;
          end
        end else if (cmd.pop) begin
          re      = 1'b1;
          raddr   = '0;
          cnt_nxt = cnt_r - CNT_W'(1);
          st_nxt  = H_POPT;
        end
      end
      H_PUP: begin
        we = 1'b1;
        if (rdata_r <= key_r) begin
          st_nxt = H_IDLE;
        end else begin
          wdata   = rdata_r;
          idx_nxt = par_idx;
          if (par_idx == '0) begin
            st_nxt = H_FIN;
          end else begin
            re    = 1'b1;
            raddr = (par_idx - CELL_W'(1)) >> 1;
          end
        end
      end
      H_FIN: begin
        we     = 1'b1;
        st_nxt = H_IDLE;
      end
      H_POPT: begin
        top_nxt = rdata_r;
        if (cnt_r == '0) begin
          st_nxt = H_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = cnt_r[CELL_W-1:0];
          st_nxt = H_POPL;
        end
      end
      H_POPL: begin
        key_nxt = rdata_r;
        idx_nxt = '0;
        st_nxt  = H_PDN;
      end
      H_PDN: begin
        if (c_w >= cnt_r) begin
          we     = 1'b1;
          st_nxt = H_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = c_w[CELL_W-1:0];
          st_nxt = H_PDC0;
        end
      end
      H_PDC0: begin
        best_nxt = rdata_r;
        cidx_nxt = c_w[CELL_W-1:0];
        if (c1_w < cnt_r) begin
          re     = 1'b1;
          raddr  = c1_w[CELL_W-1:0];
          st_nxt = H_PDC1;
        end else begin
          st_nxt = H_PDCMP;
        end
      end
      H_PDC1: begin
        if (rdata_r < best_r) begin
          best_nxt = rdata_r;
          cidx_nxt = c1_w[CELL_W-1:0];
        end
        st_nxt = H_PDCMP;
      end
      H_PDCMP: begin
        we = 1'b1;
        if (key_r <= best_r) begin
          st_nxt = H_IDLE;
        end else begin
          wdata   = best_r;
          idx_nxt = cidx_r;
          st_nxt  = H_PDN;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= wdata;
    if (re) rdata_r <= heap_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= H_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    idx_r  <= idx_nxt;
    cidx_r <= cidx_nxt;
    key_r  <= key_nxt;
    best_r <= best_nxt;
    top_r  <= top_nxt;
  end

  assign sts.busy  = (st_r != H_IDLE);
  assign sts.empty = (cnt_r == '0);
  assign sts.top   = top_r;

endmodule

### hdl/grid_a_star_path_finder_unit.sv
// ----------------------------------------------------------------------------
// grid_a_star_path_finder_unit
// 64 x 64 occupancy grid with a four-connected A* search and path readout.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered by one result word. After
// reset the block sweeps the grid free before it takes its first word. A cell
// write or an unknown request answers in the cycle after it is taken, a path
// read after a read of the path memory (like a write when the index is past
// the end of the path). A search first clears the visited map (all 4096 cells),
// then pops every reachable cell from the open-set heap and checks four
// neighbors, each a memory read followed by a check. A heap push sifts up with
// one parent read per level and a pop sifts down with a read of each child and
// a compare per level. The path is then traced back through the parent memory,
// one path write and one parent read per cell.
// ----------------------------------------------------------------------------
module grid_a_star_path_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_pos_x,
  input  logic [5:0]  in_pos_y,
  input  logic [5:0]  in_goal_x,
  input  logic [5:0]  in_goal_y,
  input  logic        in_blocked,
  input  logic [11:0] in_step_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [12:0] out_path_length,
  output logic [5:0]  out_step_x,
  output logic [5:0]  out_step_y
);
  import gapf_pkg::*;

  localparam logic [3:0] S_RST   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_POPW  = 4'd5;
  localparam logic [3:0] S_COST  = 4'd6;
  localparam logic [3:0] S_NB    = 4'd7;
  localparam logic [3:0] S_NBCHK = 4'd8;
  localparam logic [3:0] S_TG    = 4'd9;
  localparam logic [3:0] S_TGCHK = 4'd10;
  localparam logic [3:0] S_TGLEN = 4'd11;
  localparam logic [3:0] S_TRW   = 4'd12;
  localparam logic [3:0] S_TRP   = 4'd13;
  localparam logic [3:0] S_RD    = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  // memories
  logic              blk_mem  [NCELLS];
  logic              vis_mem  [NCELLS];
  logic [CELL_W-1:0] cost_mem [NCELLS];
  logic [CELL_W-1:0] par_mem  [NCELLS];
  logic [CELL_W-1:0] path_mem [NCELLS];

  logic              blk_rd_r, vis_rd_r;
  logic [CELL_W-1:0] cost_rd_r, par_rd_r, path_rd_r;

  logic              blk_we, blk_wd, blk_re;
  logic [CELL_W-1:0] blk_wa, blk_ra;
  logic              vis_we, vis_wd, vis_re;
  logic [CELL_W-1:0] vis_wa, vis_ra;
  logic              cost_we, cost_re;
  logic [CELL_W-1:0] cost_wa, cost_wd, cost_ra;
  logic              par_we, par_re;
  logic [CELL_W-1:0] par_wa, par_wd, par_ra;
  logic              path_we, path_re;
  logic [CELL_W-1:0] path_wa, path_wd, path_ra;

  // control
  logic [3:0]         st_r, st_nxt;
  logic [CNT_W-1:0]   ctr_r, ctr_nxt;
  logic [CELL_W-1:0]  start_r, start_nxt;
  logic [CELL_W-1:0]  goal_r, goal_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [CELL_W-1:0]  nb_r, nb_nxt;
  logic [CELL_W-1:0]  d_r, d_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [CELL_W-1:0]  k_r, k_nxt;
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   plen_r, plen_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [CNT_W-1:0]   out_len_r, out_len_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt;
  logic [COORD_W-1:0] out_y_r, out_y_nxt;

  heap_cmd_t hcmd;
  heap_sts_t hsts;

  logic               accept;
  logic               nb_ok;
  logic [CELL_W-1:0]  nb_cell;
  logic [COORD_W-1:0] cx, cy;

  gapf_heap u_heap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hcmd),
    .sts   (hsts)
  );

  function automatic logic [COORD_W:0] adiff(input logic [COORD_W-1:0] a,
                                            input logic [COORD_W-1:0] b);
    adiff = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  function automatic key_t mk_key(input logic [CELL_W-1:0] g_cost,
                                  input logic [CELL_W-1:0] c,
                                  input logic [CELL_W-1:0] g);
    logic [F_W-1:0] f;
    f = F_W'(g_cost) + F_W'(adiff(g[COORD_W-1:0], c[COORD_W-1:0]))
      + F_W'(adiff(g[CELL_W-1:COORD_W], c[CELL_W-1:COORD_W]));
    mk_key = {f, c};
  endfunction

  assign in_stall = !((st_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  assign cx = cell_r[COORD_W-1:0];
  assign cy = cell_r[CELL_W-1:COORD_W];

  // neighbor of the current cell in direction dir_r: up, down, left, right
  always_comb begin
    nb_ok   = 1'b0;
    nb_cell = cell_r;
    case (dir_r)
      2'd0: begin
        nb_ok   = (cy != COORD_W'(GRID_H - 1));
        nb_cell = {cy + COORD_W'(1), cx};
      end
      2'd1: begin
        nb_ok   = (cy != '0);
        nb_cell = {cy - COORD_W'(1), cx};
      end
      2'd2: begin
        nb_ok   = (cx != '0);
        nb_cell = {cy, cx - COORD_W'(1)};
      end
      2'd3: begin
        nb_ok   = (cx != COORD_W'(GRID_W - 1));
        nb_cell = {cy, cx + COORD_W'(1)};
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    ctr_nxt       = ctr_r;
    start_nxt     = start_r;
    goal_nxt      = goal_r;
    cell_nxt      = cell_r;
    nb_nxt        = nb_r;
    d_nxt         = d_r;
    dir_nxt       = dir_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    plen_nxt      = plen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_len_nxt   = out_len_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;

    hcmd = '0;
    blk_we = 1'b0; blk_wa = ctr_r[CELL_W-1:0]; blk_wd = 1'b0;
    blk_re = 1'b0; blk_ra = nb_cell;
    vis_we = 1'b0; vis_wa = ctr_r[CELL_W-1:0]; vis_wd = 1'b0;
    vis_re = 1'b0; vis_ra = nb_cell;
    cost_we = 1'b0; cost_wa = nb_r; cost_wd = d_r + CELL_W'(1);
    cost_re = 1'b0; cost_ra = hsts.top[CELL_W-1:0];
    par_we = 1'b0; par_wa = nb_r; par_wd = cell_r;
    par_re = 1'b0; par_ra = cell_r;
    path_we = 1'b0; path_wa = k_r; path_wd = cell_r;
    path_re = 1'b0; path_ra = in_step_index;

    case (st_r)
      S_RST: begin
        blk_we = 1'b1;
        vis_we = 1'b1;
        ctr_nxt = ctr_r + CNT_W'(1);
        if (ctr_r == CNT_W'(NCELLS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          out_found_nxt = found_r;
          out_len_nxt   = plen_r;
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          case (in_req_type)
            REQ_WRITE: begin
              blk_we        = 1'b1;
              blk_wa        = {in_pos_y, in_pos_x};
              blk_wd        = in_blocked;
              out_valid_nxt = 1'b1;
            end
            REQ_SEARCH: begin
              start_nxt = {in_pos_y, in_pos_x};
              goal_nxt  = {in_goal_y, in_goal_x};
              found_nxt = 1'b0;
              plen_nxt  = '0;
              ctr_nxt   = '0;
              hcmd.clr  = 1'b1;
              st_nxt    = S_CLR;
            end
            REQ_READ: begin
              if (CNT_W'(in_step_index) < plen_r) begin
                path_re = 1'b1;
                st_nxt  = S_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        vis_we  = 1'b1;
        ctr_nxt = ctr_r + CNT_W'(1);
        if (ctr_r == CNT_W'(NCELLS - 1)) st_nxt = S_START;
      end
      S_START: begin
        vis_we  = 1'b1; vis_wa = start_r; vis_wd = 1'b1;
        cost_we = 1'b1; cost_wa = start_r; cost_wd = '0;
        par_we  = 1'b1; par_wa = start_r; par_wd = start_r;
        hcmd.push = 1'b1;
        hcmd.key  = mk_key('0, start_r, goal_r);
        st_nxt    = S_POP;
      end
      S_POP: begin
        if (!hsts.busy) begin
          if (hsts.empty) begin
            st_nxt = S_TG;
          end else begin
            hcmd.pop = 1'b1;
            st_nxt   = S_POPW;
          end
        end
      end
      S_POPW: begin
        if (!hsts.busy) begin
          cell_nxt = hsts.top[CELL_W-1:0];
          cost_re  = 1'b1;
          st_nxt   = S_COST;
        end
      end
      S_COST: begin
        d_nxt   = cost_rd_r;
        dir_nxt = '0;
        st_nxt  = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          nb_nxt = nb_cell;
          vis_re = 1'b1;
          blk_re = 1'b1;
          st_nxt = S_NBCHK;
        end else begin
          dir_nxt = dir_r + 2'd1;
          st_nxt  = (dir_r == 2'd3) ? S_POP : S_NB;
        end
      end
      S_NBCHK: begin
        // a push from the previous direction may still be sifting
        if (!hsts.busy) begin
          if (!vis_rd_r && !blk_rd_r) begin
            vis_we    = 1'b1; vis_wa = nb_r; vis_wd = 1'b1;
            cost_we   = 1'b1;
            par_we    = 1'b1;
            hcmd.push = 1'b1;
            hcmd.key  = mk_key(d_r + CELL_W'(1), nb_r, goal_r);
          end
          dir_nxt = dir_r + 2'd1;
          st_nxt  = (dir_r == 2'd3) ? S_POP : S_NB;
        end
      end
      S_TG: begin
        vis_re = 1'b1;
        vis_ra = goal_r;
        st_nxt = S_TGCHK;
      end
      S_TGCHK: begin
        if (vis_rd_r) begin
          cost_re = 1'b1;
          cost_ra = goal_r;
          st_nxt  = S_TGLEN;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_TGLEN: begin
        found_nxt = 1'b1;
        plen_nxt  = CNT_W'(cost_rd_r) + CNT_W'(1);
        k_nxt     = cost_rd_r;
        cell_nxt  = goal_r;
        st_nxt    = S_TRW;
      end
      S_TRW: begin
        path_we = 1'b1;
        par_re  = 1'b1;
        if (k_r == '0) begin
          st_nxt = S_DONE;
        end else begin
          k_nxt  = k_r - CELL_W'(1);
          st_nxt = S_TRP;
        end
      end
      S_TRP: begin
        cell_nxt = par_rd_r;
        st_nxt   = S_TRW;
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_x_nxt     = path_rd_r[COORD_W-1:0];
        out_y_nxt     = path_rd_r[CELL_W-1:COORD_W];
        st_nxt        = S_IDLE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = found_r;
        out_len_nxt   = plen_r;
        out_x_nxt     = '0;
        out_y_nxt     = '0;
        st_nxt        = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    if (blk_re) blk_rd_r <= blk_mem[blk_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_re) vis_rd_r <= vis_mem[vis_ra];
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    if (cost_re) cost_rd_r <= cost_mem[cost_ra];
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_rd_r <= par_mem[par_ra];
    if (path_we) path_mem[path_wa] <= path_wd;
    if (path_re) path_rd_r <= path_mem[path_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_RST;
      ctr_r       <= '0;
      found_r     <= 1'b0;
      plen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ctr_r       <= ctr_nxt;
      found_r     <= found_nxt;
      plen_r      <= plen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r     <= start_nxt;
    goal_r      <= goal_nxt;
    cell_r      <= cell_nxt;
    nb_r        <= nb_nxt;
    d_r         <= d_nxt;
    dir_r       <= dir_nxt;
    k_r         <= k_nxt;
    out_found_r <= out_found_nxt;
    out_len_r   <= out_len_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_path_length = out_len_r;
  assign out_step_x      = out_x_r;
  assign out_step_y      = out_y_r;

endmodule
